[sv/ppc_pkg.sv]
`timescale 1ns / 1ps

package ppc_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int NORMAL_Z_RESET = 256;
    localparam int REG_ADDR_W     = 3;

    typedef enum logic [REG_ADDR_W-1:0] {
        REG_NORMAL_X = 3'd0,
        REG_NORMAL_Y = 3'd1,
        REG_NORMAL_Z = 3'd2,
        REG_POINT_X  = 3'd3,
        REG_POINT_Y  = 3'd4,
        REG_POINT_Z  = 3'd5
    } reg_addr_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST,
        ST_EDGE,
        ST_MUL,
        ST_DIV,
        ST_QUOT,
        ST_PUSH_I,
        ST_PUSH_E,
        ST_EDGE_END,
        ST_FINISH
    } state_t;

endpackage

[sv/polygon_plane_clipper_top.sv]
`timescale 1ns / 1ps
// Channel | Dir | tdata (low bit up)           | tlast           | tuser
// s_*     | in  | vertex_x, vertex_y, vertex_z | end_of_polygon  | -
// m_*     | out | out_x, out_y, out_z          | final_vertex    | clipped_empty
// wr_*    | in  | register write: normal_x/y/z, point_x/y/z at index 0..5
//
// One request at a time. Distance: products summed on one shared multiplier, plus
// edge bookkeeping. A crossing edge adds, per coordinate, a bit-serial shift-add for
// the numerator, then a restoring divide, one bit a cycle.
// Reset clears control and configuration at once; no clearing pass.
// s_tready drops while the sequencer works; a held output stalls only a push or the
// final result.

module polygon_plane_clipper_top #(
    parameter int COORD_BITS = ppc_pkg::COORD_BITS_DEF,
    localparam int TW = ((3 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TW-1:0]         s_tdata,   // vertex_x, vertex_y, vertex_z
    input  logic                  s_tlast,   // end_of_polygon
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TW-1:0]         m_tdata,   // out_x, out_y, out_z
    output logic                  m_tlast,   // final_vertex
    output logic [0:0]            m_tuser,   // clipped_empty
    input  logic                  wr_en,
    input  logic [ppc_pkg::REG_ADDR_W-1:0] wr_addr,
    input  logic [COORD_BITS-1:0] wr_data
);

    localparam int C    = COORD_BITS;
    localparam int DIFW = C + 1;          // v - p, e - s
    localparam int PRW  = C + DIFW;       // one distance product
    localparam int DW   = PRW + 2;        // sum of three products
    localparam int DENW = DW + 1;         // |ds - de|
    localparam int NW   = C + DENW + 2;   // numerator
    localparam int QW   = C + 1;          // quotient magnitude
    localparam int CW   = $clog2(DENW);

    ppc_pkg::state_t state_reg, state_next;

    logic signed [C-1:0]  normal_reg [3];
    logic signed [C-1:0]  normal_next [3];
    logic signed [C-1:0]  point_reg [3];
    logic signed [C-1:0]  point_next [3];
    logic signed [C-1:0]  v_reg [3], v_next [3];
    logic signed [C-1:0]  first_reg [3], first_next [3];
    logic signed [C-1:0]  prev_reg [3], prev_next [3];
    logic signed [C-1:0]  pend_reg [3], pend_next [3];
    logic signed [C-1:0]  ip_reg [3], ip_next [3];
    logic signed [DW-1:0] d_reg, d_next;
    logic signed [DW-1:0] dfirst_reg, dfirst_next;
    logic signed [DW-1:0] dprev_reg, dprev_next;
    logic                 last_reg, last_next;
    logic                 started_reg, started_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 closing_reg, closing_next;
    logic [1:0]           ci_reg, ci_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [DENW-1:0]      den_reg, den_next;
    logic [DENW-1:0]      scale_reg, scale_next;
    logic signed [NW-1:0] acc_reg, acc_next;
    logic                 neg_reg, neg_next;
    logic [NW-1:0]        rem_reg, rem_next;
    logic [NW-1:0]        dsh_reg, dsh_next;
    logic [QW-1:0]        q_reg, q_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [C-1:0]  out_reg [3], out_next [3];
    logic                 out_last_reg, out_last_next;
    logic                 out_empty_reg, out_empty_next;

    // edge operands: main edge prev->v, closing edge v->first
    logic signed [C-1:0]  s_vec [3];
    logic signed [C-1:0]  e_vec [3];
    logic signed [DW-1:0] ds, de;
    logic                 s_in, e_in;
    logic                 accept;
    logic                 push_ok;
    logic signed [DIFW-1:0] diffp;
    logic signed [PRW-1:0]  prod;
    logic signed [DW-1:0]   d_sum;
    logic signed [DENW-1:0] den_raw;
    logic signed [DIFW-1:0] ediff;
    logic signed [NW-1:0]   mul_step;
    logic [NW-1:0]          rem_sub;
    logic signed [QW:0]     q_signed;
    logic signed [C-1:0]    q_sat;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s_vec[i] = closing_reg ? v_reg[i] : prev_reg[i];
            e_vec[i] = closing_reg ? first_reg[i] : v_reg[i];
        end
    end

    assign ds       = closing_reg ? d_reg : dprev_reg;
    assign de       = closing_reg ? dfirst_reg : d_reg;
    assign s_in     = !ds[DW-1];
    assign e_in     = !de[DW-1];
    assign s_tready = (state_reg == ppc_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign push_ok  = !(pend_valid_reg && out_valid_reg);

    // shared multiplier for the distance terms
    assign diffp = DIFW'(v_reg[ci_reg]) - DIFW'(point_reg[ci_reg]);
    assign prod  = PRW'(normal_reg[ci_reg]) * PRW'(diffp);
    assign d_sum = d_reg + DW'(prod);

    assign den_raw = DENW'(ds) - DENW'(de);
    assign ediff   = DIFW'(e_vec[ci_reg]) - DIFW'(s_vec[ci_reg]);

    // Horner step of s*den + (e-s)*scale, MSB first
    assign mul_step = (acc_reg <<< 1)
                    + (den_reg[cnt_reg] ? NW'(s_vec[ci_reg]) : NW'(0))
                    + (scale_reg[cnt_reg] ? NW'(ediff) : NW'(0));

    assign rem_sub  = rem_reg - dsh_reg;
    assign q_signed = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

    always_comb
    begin
        if (q_signed[QW:C-1] == '0 || q_signed[QW:C-1] == '1)
            q_sat = q_signed[C-1:0];
        else if (q_signed[QW])
            q_sat = {1'b1, {(C-1){1'b0}}};
        else
            q_sat = {1'b0, {(C-1){1'b1}}};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ppc_pkg::ST_IDLE:
                if (accept)
                    state_next = ppc_pkg::ST_DIST;
            ppc_pkg::ST_DIST:
                if (ci_reg == 2'd2)
                begin
                    if (started_reg || last_reg)
                        state_next = ppc_pkg::ST_EDGE;
                    else
                        state_next = ppc_pkg::ST_IDLE;
                end
            ppc_pkg::ST_EDGE:
                priority if (s_in && e_in)
                    state_next = ppc_pkg::ST_PUSH_E;
                else if (s_in || e_in)
                    state_next = ppc_pkg::ST_MUL;
                else
                    state_next = ppc_pkg::ST_EDGE_END;
            ppc_pkg::ST_MUL:
                if (cnt_reg == '0)
                    state_next = ppc_pkg::ST_DIV;
            ppc_pkg::ST_DIV:
                if (cnt_reg == '0)
                    state_next = ppc_pkg::ST_QUOT;
            ppc_pkg::ST_QUOT:
                state_next = (ci_reg == 2'd2) ? ppc_pkg::ST_PUSH_I : ppc_pkg::ST_MUL;
            ppc_pkg::ST_PUSH_I:
                if (push_ok)
                    state_next = e_in ? ppc_pkg::ST_PUSH_E : ppc_pkg::ST_EDGE_END;
            ppc_pkg::ST_PUSH_E:
                if (push_ok)
                    state_next = ppc_pkg::ST_EDGE_END;
            ppc_pkg::ST_EDGE_END:
                priority if (closing_reg)
                    state_next = ppc_pkg::ST_FINISH;
                else if (last_reg)
                    state_next = ppc_pkg::ST_EDGE;
                else
                    state_next = ppc_pkg::ST_IDLE;
            ppc_pkg::ST_FINISH:
                if (!out_valid_reg)
                    state_next = ppc_pkg::ST_IDLE;
            default:
                state_next = ppc_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        normal_next     = normal_reg;
        point_next      = point_reg;
        v_next          = v_reg;
        first_next      = first_reg;
        prev_next       = prev_reg;
        pend_next       = pend_reg;
        ip_next         = ip_reg;
        d_next          = d_reg;
        dfirst_next     = dfirst_reg;
        dprev_next      = dprev_reg;
        last_next       = last_reg;
        started_next    = started_reg;
        pend_valid_next = pend_valid_reg;
        closing_next    = closing_reg;
        ci_next         = ci_reg;
        cnt_next        = cnt_reg;
        den_next        = den_reg;
        scale_next      = scale_reg;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        rem_next        = rem_reg;
        dsh_next        = dsh_reg;
        q_next          = q_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        if (wr_en)
        begin
            unique case (wr_addr)
                ppc_pkg::REG_NORMAL_X: normal_next[0] = wr_data;
                ppc_pkg::REG_NORMAL_Y: normal_next[1] = wr_data;
                ppc_pkg::REG_NORMAL_Z: normal_next[2] = wr_data;
                ppc_pkg::REG_POINT_X:  point_next[0]  = wr_data;
                ppc_pkg::REG_POINT_Y:  point_next[1]  = wr_data;
                ppc_pkg::REG_POINT_Z:  point_next[2]  = wr_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ppc_pkg::ST_IDLE:
                if (accept)
                begin
                    v_next[0] = s_tdata[C-1:0];
                    v_next[1] = s_tdata[2*C-1:C];
                    v_next[2] = s_tdata[3*C-1:2*C];
                    last_next = s_tlast;
                    d_next    = '0;
                    ci_next   = 2'd0;
                end
            ppc_pkg::ST_DIST:
            begin
                d_next  = d_sum;
                ci_next = ci_reg + 2'd1;
                if (ci_reg == 2'd2)
                begin
                    closing_next = 1'b0;
                    if (!started_reg)
                    begin
                        first_next   = v_reg;
                        dfirst_next  = d_sum;
                        prev_next    = v_reg;
                        dprev_next   = d_sum;
                        started_next = 1'b1;
                        closing_next = 1'b1;
                    end
                end
            end
            ppc_pkg::ST_EDGE:
            begin
                den_next   = den_raw[DENW-1] ? DENW'(-den_raw) : DENW'(den_raw);
                scale_next = s_in ? DENW'(ds) : DENW'(-ds);
                ci_next    = 2'd0;
                acc_next   = '0;
                cnt_next   = CW'(DENW - 1);
            end
            ppc_pkg::ST_MUL:
            begin
                acc_next = mul_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    neg_next = mul_step[NW-1];
                    rem_next = mul_step[NW-1] ? NW'(-mul_step) : NW'(mul_step);
                    dsh_next = NW'(den_reg) << (QW - 1);
                    q_next   = '0;
                    cnt_next = CW'(QW - 1);
                end
            end
            ppc_pkg::ST_DIV:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_next = rem_sub;
                    q_next   = {q_reg[QW-2:0], 1'b1};
                end
                else
                    q_next = {q_reg[QW-2:0], 1'b0};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
            end
            ppc_pkg::ST_QUOT:
            begin
                ip_next[ci_reg] = q_sat;
                ci_next         = ci_reg + 2'd1;
                acc_next        = '0;
                cnt_next        = CW'(DENW - 1);
            end
            ppc_pkg::ST_PUSH_I, ppc_pkg::ST_PUSH_E:
                if (push_ok)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = pend_reg;
                        out_last_next  = 1'b0;
                        out_empty_next = 1'b0;
                    end
                    pend_next       = (state_reg == ppc_pkg::ST_PUSH_I) ? ip_reg : e_vec;
                    pend_valid_next = 1'b1;
                end
            ppc_pkg::ST_EDGE_END:
                if (!closing_reg)
                begin
                    prev_next    = v_reg;
                    dprev_next   = d_reg;
                    closing_next = last_reg;
                end
            ppc_pkg::ST_FINISH:
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    out_empty_next = !pend_valid_reg;
                    for (int i = 0; i < 3; i++)
                        out_next[i] = pend_valid_reg ? pend_reg[i] : '0;
                    pend_valid_next = 1'b0;
                    started_next    = 1'b0;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ppc_pkg::ST_IDLE;
            started_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            closing_reg    <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                normal_reg[i] <= (i == 2) ? C'(ppc_pkg::NORMAL_Z_RESET) : '0;
                point_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            started_reg    <= started_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            closing_reg    <= closing_next;
            normal_reg     <= normal_next;
            point_reg      <= point_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg         <= v_next;
        first_reg     <= first_next;
        prev_reg      <= prev_next;
        pend_reg      <= pend_next;
        ip_reg        <= ip_next;
        d_reg         <= d_next;
        dfirst_reg    <= dfirst_next;
        dprev_reg     <= dprev_next;
        last_reg      <= last_next;
        ci_reg        <= ci_next;
        cnt_reg       <= cnt_next;
        den_reg       <= den_next;
        scale_reg     <= scale_next;
        acc_reg       <= acc_next;
        neg_reg       <= neg_next;
        rem_reg       <= rem_next;
        dsh_reg       <= dsh_next;
        q_reg         <= q_next;
        out_reg       <= out_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = TW'({out_reg[2], out_reg[1], out_reg[0]});
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_empty_reg;

endmodule
